FILE: rtl/core/mrwt_pkg.sv
// Shared widths, constants and modular add for the Miller-Rabin witness test.
package mrwt_pkg;

  localparam int CANDIDATE_BITS = 31;
  localparam int CNT_BITS = $clog2(CANDIDATE_BITS + 1);
  localparam int SHIFT_BITS = $clog2(CANDIDATE_BITS);

  typedef logic [CANDIDATE_BITS-1:0] word_t;
  typedef logic [CANDIDATE_BITS:0] wide_t;

  localparam word_t ONE = word_t'(1);
  localparam word_t TWO = word_t'(2);

  function automatic word_t add_mod(word_t x, word_t y, word_t n);
    wide_t t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[CANDIDATE_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/mrwt_remainder.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module mrwt_remainder
  import mrwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t remainder
);

  logic [CNT_BITS-1:0] cnt;
  word_t shreg;
  word_t nr;
  wide_t trial;
  wide_t trial_sub;
  word_t remainder_next;

  always_comb begin
    trial = {remainder, shreg[CANDIDATE_BITS-1]};
    trial_sub = trial - {1'b0, nr};
    if (trial >= {1'b0, nr}) begin
      remainder_next = trial_sub[CANDIDATE_BITS-1:0];
    end else begin
      remainder_next = trial[CANDIDATE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(CANDIDATE_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      shreg <= dividend;
      nr <= divisor;
    end else if (cnt != '0) begin
      remainder <= remainder_next;
      shreg <= {shreg[CANDIDATE_BITS-2:0], 1'b0};
    end
  end

endmodule

FILE: rtl/core/mrwt_mulmod.sv
// Bit-serial shift-and-add modular multiplier: one multiplier bit per cycle.
module mrwt_mulmod
  import mrwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t op_x,
  input  word_t op_y,
  input  word_t modulus,
  output logic  done,
  output word_t product
);

  logic [CNT_BITS-1:0] cnt;
  word_t xr;
  word_t yr;
  word_t nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(CANDIDATE_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      xr <= op_x;
      yr <= op_y;
      nr <= modulus;
    end else if (cnt != '0) begin
      if (yr[0]) begin
        product <= add_mod(product, xr, nr);
      end
      xr <= add_mod(xr, xr, nr);
      yr <= {1'b0, yr[CANDIDATE_BITS-1:1]};
    end
  end

endmodule

FILE: rtl/core/miller_rabin_witness_test_unit.sv
// Top level: sequencer for the strong probable-prime test on one base.
//
//   channel | signals                             | direction
//   --------+-------------------------------------+----------
//   in      | in_valid, in_ready, candidate,      | into block
//           | witness_base                        |
//   out     | out_valid, out_ready, verdict       | out of block
//
// One transaction is worked on at a time; in_ready is high only while idle.
// Trivial candidates (below 2, even) go straight to the done state. Otherwise the time
// is set by the remainder unit and the shared bit-serial modular multiplier.
// Reset clears the sequencer and the output valid; no memory is cleared.
// A finished verdict waits in the output register and does not block the next input.
module miller_rabin_witness_test_unit
  import mrwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t candidate,
  input  word_t witness_base,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  verdict
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_SPLIT      = 11'b00000000010,
    S_REDUCE     = 11'b00000000100,
    S_EXP_CHECK  = 11'b00000001000,
    S_EXP_MUL    = 11'b00000010000,
    S_EXP_SQR    = 11'b00000100000,
    S_TEST_FIRST = 11'b00001000000,
    S_LOOP       = 11'b00010000000,
    S_SQ_WAIT    = 11'b00100000000,
    S_TEST_SQ    = 11'b01000000000,
    S_DONE       = 11'b10000000000
  } state_t;

  state_t state;
  logic rem_start;
  logic mul_start;
  logic rem_done;
  logic mul_done;
  word_t rem_value;
  word_t mul_value;
  word_t mul_x;
  word_t mul_y;
  word_t n_reg;
  word_t a_reg;
  word_t d;
  logic [SHIFT_BITS-1:0] s;
  word_t base;
  word_t r;
  logic verdict_reg;
  word_t nm1;
  logic out_load;

  assign in_ready = (state == S_IDLE);
  assign nm1 = n_reg - ONE;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      S_EXP_MUL: begin
        mul_x = r;
        mul_y = base;
      end
      S_SQ_WAIT: begin
        mul_x = r;
        mul_y = r;
      end
      default: begin
        mul_x = base;
        mul_y = base;
      end
    endcase
  end

  mrwt_remainder u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (a_reg),
    .divisor  (n_reg),
    .done     (rem_done),
    .remainder(rem_value)
  );

  mrwt_mulmod u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .op_x   (mul_x),
    .op_y   (mul_y),
    .modulus(n_reg),
    .done   (mul_done),
    .product(mul_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rem_start <= 1'b0;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rem_start <= 1'b0;
      mul_start <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (candidate < TWO || candidate == TWO || !candidate[0]) begin
              state <= S_DONE;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (d[0]) begin
            state <= S_REDUCE;
            rem_start <= 1'b1;
          end
        end
        S_REDUCE: begin
          if (rem_done) begin
            state <= S_EXP_CHECK;
          end
        end
        S_EXP_CHECK: begin
          if (d == '0) begin
            state <= S_TEST_FIRST;
          end else if (d[0]) begin
            state <= S_EXP_MUL;
            mul_start <= 1'b1;
          end else begin
            state <= S_EXP_SQR;
            mul_start <= 1'b1;
          end
        end
        S_EXP_MUL: begin
          if (mul_done) begin
            state <= S_EXP_SQR;
            mul_start <= 1'b1;
          end
        end
        S_EXP_SQR: begin
          if (mul_done) begin
            state <= S_EXP_CHECK;
          end
        end
        S_TEST_FIRST: begin
          if (r == ONE || r == nm1) begin
            state <= S_DONE;
          end else begin
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (s == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_SQ_WAIT;
            mul_start <= 1'b1;
          end
        end
        S_SQ_WAIT: begin
          if (mul_done) begin
            state <= S_TEST_SQ;
          end
        end
        S_TEST_SQ: begin
          if (r == nm1) begin
            state <= S_DONE;
          end else begin
            state <= S_LOOP;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict <= verdict_reg;
    end
    unique case (state)
      S_IDLE: begin
        n_reg <= candidate;
        a_reg <= witness_base;
        d <= candidate - ONE;
        s <= '0;
        verdict_reg <= (candidate == TWO);
      end
      S_SPLIT: begin
        if (!d[0]) begin
          d <= {1'b0, d[CANDIDATE_BITS-1:1]};
          s <= s + 1'b1;
        end
      end
      S_REDUCE: begin
        if (rem_done) begin
          base <= (rem_value < TWO) ? TWO : rem_value;
          r <= ONE;
        end
      end
      S_EXP_MUL: begin
        if (mul_done) begin
          r <= mul_value;
        end
      end
      S_EXP_SQR: begin
        if (mul_done) begin
          base <= mul_value;
          d <= {1'b0, d[CANDIDATE_BITS-1:1]};
        end
      end
      S_TEST_FIRST: begin
        verdict_reg <= (r == ONE || r == nm1);
        s <= s - 1'b1;
      end
      S_LOOP: begin
        if (s != '0) begin
          s <= s - 1'b1;
        end
      end
      S_SQ_WAIT: begin
        if (mul_done) begin
          r <= mul_value;
        end
      end
      S_TEST_SQ: begin
        verdict_reg <= (r == nm1);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/mrwt_checker.sv
// Port-level assertions for the witness test unit, bound to the top level.
module mrwt_checker
  import mrwt_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input word_t candidate,
  input logic  out_valid,
  input logic  out_ready,
  input logic  verdict
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("Stalled result was dropped or changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a transaction is in progress.");

  a_trivial_composite: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid &&
    (candidate < TWO || (!candidate[0] && candidate != TWO))
    |-> ##2 out_valid && !verdict)
    else $error("Trivial composite candidate not reported as composite.");

  a_two_prime: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && candidate == TWO
    |-> ##2 out_valid && verdict)
    else $error("Candidate two not reported as prime.");

endmodule

bind miller_rabin_witness_test_unit mrwt_checker u_mrwt_checker (.*);

FILE: tb/sv/miller_rabin_witness_test_unit_tb.sv
// Self-checking testbench for the Miller-Rabin witness test unit with its own verdict predictor.
`timescale 1ns / 1ps

module miller_rabin_witness_test_unit_tb;
  import mrwt_pkg::*;

  typedef struct {
    word_t       cand;
    word_t       base;
    int unsigned gap;
    bit          drain;
  } trial_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t candidate = '0;
  word_t witness_base = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  verdict;

  trial_t      trial_q[$];
  logic        expected_verdicts[$];
  int unsigned tx_wait = 0;
  int unsigned rx_hold = 0;
  bit          rx_calm = 1'b0;
  logic        want;
  int          errors = 0;

  miller_rabin_witness_test_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .candidate   (candidate),
    .witness_base(witness_base),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict)
  );

  function automatic longint unsigned mod_sum(longint unsigned x, longint unsigned y,
                                              longint unsigned n);
    longint unsigned t;
    t = x + y;
    if (t >= n) begin
      t = t - n;
    end
    return t;
  endfunction

  function automatic longint unsigned mod_product(longint unsigned x, longint unsigned y,
                                                  longint unsigned n);
    longint unsigned acc;
    acc = 0;
    while (y != 0) begin
      if ((y & 1) != 0) begin
        acc = mod_sum(acc, x, n);
      end
      x = mod_sum(x, x, n);
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic longint unsigned mod_power(longint unsigned b, longint unsigned e,
                                                longint unsigned n);
    longint unsigned r;
    r = 1 % n;
    while (e != 0) begin
      if ((e & 1) != 0) begin
        r = mod_product(r, b, n);
      end
      b = mod_product(b, b, n);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic strong_probable_prime(word_t cand, word_t base_in);
    longint unsigned n;
    longint unsigned a;
    longint unsigned nm1;
    longint unsigned d;
    longint unsigned x;
    int              s;
    n = cand;
    a = base_in;
    s = 0;
    if (n < 2) begin
      return 1'b0;
    end
    if (n == 2) begin
      return 1'b1;
    end
    if ((n & 1) == 0) begin
      return 1'b0;
    end
    nm1 = n - 1;
    d = nm1;
    while ((d & 1) == 0) begin
      d = d >> 1;
      s++;
    end
    a = a % n;
    if (a < 2) begin
      a = 2;
    end
    x = mod_power(a, d, n);
    if (x == 1 || x == nm1) begin
      return 1'b1;
    end
    for (int i = 1; i < s; i++) begin
      x = mod_product(x, x, n);
      if (x == nm1) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(0, 2);
    end
    if (r < 95) begin
      return $urandom_range(3, 20);
    end
    return $urandom_range(50, 300);
  endfunction

  function automatic void add_trial(word_t cand, word_t base, bit calm, bit drain);
    trial_t t;
    t.cand = cand;
    t.base = base;
    t.gap = calm ? 0 : idle_span();
    t.drain = drain;
    trial_q.push_back(t);
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_verdicts.push_back(strong_probable_prime(candidate, witness_base));
      end
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (trial_q.size() != 0 &&
                   !(trial_q[0].drain && expected_verdicts.size() != 0)) begin
        in_valid <= 1'b1;
        candidate <= trial_q[0].cand;
        witness_base <= trial_q[0].base;
        tx_wait <= trial_q[0].gap;
        void'(trial_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("verdict: unexpected transaction, actual %0d", verdict);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict !== want) begin
            $error("verdict: expected %0d, actual %0d", want, verdict);
            errors++;
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          rx_calm <= !rx_calm;
        end
      end
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_hold <= idle_span();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    word_t       cand;
    word_t       base;
    word_t       mask;
    int unsigned width;
    int unsigned kind;

    add_trial(word_t'(0), word_t'(0), 1'b1, 1'b0);
    add_trial(word_t'(1), word_t'(5), 1'b1, 1'b0);
    add_trial(word_t'(2), word_t'(0), 1'b1, 1'b0);
    add_trial(word_t'(2), word_t'('h7FFFFFFF), 1'b1, 1'b0);
    add_trial(word_t'(4), word_t'(3), 1'b0, 1'b0);
    add_trial(word_t'('h7FFFFFFE), word_t'(7), 1'b0, 1'b0);
    add_trial(word_t'(3), word_t'('h7FFFFFFF), 1'b0, 1'b0);
    add_trial(word_t'(3), word_t'(1), 1'b0, 1'b0);
    add_trial(word_t'(5), word_t'(5), 1'b1, 1'b0);
    add_trial(word_t'(5), word_t'(6), 1'b1, 1'b0);
    add_trial(word_t'(7), word_t'(6), 1'b0, 1'b0);
    add_trial(word_t'('h7FFFFFFF), word_t'('h7FFFFFFF), 1'b0, 1'b0);
    add_trial(word_t'('h7FFFFFFF), word_t'('h7FFFFFFE), 1'b0, 1'b1);
    add_trial(word_t'('h7FFFFFFF), word_t'('h55555555), 1'b1, 1'b0);
    add_trial(word_t'(2047), word_t'(2), 1'b1, 1'b0);
    add_trial(word_t'(2047), word_t'(3), 1'b0, 1'b0);
    add_trial(word_t'(561), word_t'(2), 1'b0, 1'b0);
    add_trial(word_t'(1073741825), word_t'(3), 1'b0, 1'b0);
    add_trial(word_t'(2013265921), word_t'(31), 1'b1, 1'b0);
    add_trial(word_t'(2013265921), word_t'('h2AAAAAAA), 1'b0, 1'b0);
    add_trial(word_t'(25), word_t'(7), 1'b0, 1'b0);
    add_trial(word_t'(9), word_t'(2), 1'b0, 1'b0);
    add_trial(word_t'(15), word_t'(2), 1'b0, 1'b0);

    for (int i = 0; i < 200; i++) begin
      width = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(2, 16);
      mask = (width == 31) ? '1 : word_t'((1 << width) - 1);
      cand = word_t'($urandom) & mask;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        cand[0] = 1'b1;
      end else if (kind == 8) begin
        cand = word_t'($urandom_range(0, 4));
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        base = word_t'($urandom);
      end else if (kind == 6) begin
        base = word_t'($urandom_range(0, 1));
      end else if (kind == 7) begin
        base = cand;
      end else if (kind == 8) begin
        base = cand - ONE;
      end else begin
        base = cand + ONE;
      end
      add_trial(cand, base, ((i / 25) % 3) == 1, i == 100);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (trial_q.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (3000) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
